>>> sv/sslex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sslex_pkg;

  localparam int CH_W   = 21;
  localparam int EN_W   = 3;
  localparam int OUT_W  = 16;
  localparam int QDEPTH = 2;

  // enable bit positions
  localparam int EN_STR = 0;
  localparam int EN_Q   = 1;
  localparam int EN_CMT = 2;

  // verdict codes
  localparam logic [1:0] V_STR  = 2'd0;
  localparam logic [1:0] V_Q    = 2'd1;
  localparam logic [1:0] V_CMT  = 2'd2;
  localparam logic [1:0] V_NONE = 2'd3;

  localparam logic [CH_W-1:0] CH_NUL    = 21'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 21'h09;
  localparam logic [CH_W-1:0] CH_LF     = 21'h0A;
  localparam logic [CH_W-1:0] CH_VT     = 21'h0B;
  localparam logic [CH_W-1:0] CH_FF     = 21'h0C;
  localparam logic [CH_W-1:0] CH_CR     = 21'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 21'h20;
  localparam logic [CH_W-1:0] CH_QUOTE  = 21'h27;
  localparam logic [CH_W-1:0] CH_LPAREN = 21'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 21'h29;
  localparam logic [CH_W-1:0] CH_STAR   = 21'h2A;
  localparam logic [CH_W-1:0] CH_SLASH  = 21'h2F;
  localparam logic [CH_W-1:0] CH_LT     = 21'h3C;
  localparam logic [CH_W-1:0] CH_GT     = 21'h3E;
  localparam logic [CH_W-1:0] CH_UC_N   = 21'h4E;
  localparam logic [CH_W-1:0] CH_UC_Q   = 21'h51;
  localparam logic [CH_W-1:0] CH_LBRACK = 21'h5B;
  localparam logic [CH_W-1:0] CH_RBRACK = 21'h5D;
  localparam logic [CH_W-1:0] CH_LC_N   = 21'h6E;
  localparam logic [CH_W-1:0] CH_LC_Q   = 21'h71;
  localparam logic [CH_W-1:0] CH_LBRACE = 21'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 21'h7D;

  typedef struct packed {
    logic zero;
    logic ws;      // space, tab, CR, LF, FF, VT
    logic fbd;     // not allowed as q delimiter
    logic quote;
    logic slash;
    logic star;
    logic is_n;
    logic is_q;
  } cls_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [EN_W-1:0] en;
    cls_t            cls;
    logic [CH_W-1:0] partner;
  } item_t;

  function automatic logic [CH_W-1:0] partner_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] p;
    unique case (c)
      CH_LBRACK: p = CH_RBRACK;
      CH_LBRACE: p = CH_RBRACE;
      CH_LPAREN: p = CH_RPAREN;
      CH_LT:     p = CH_GT;
      default:   p = c;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> sv/sslex_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sslex_front (
  input  wire logic [sslex_pkg::CH_W-1:0] ch,
  input  wire logic                       want_string,
  input  wire logic                       want_qstring,
  input  wire logic                       want_comment,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       q_full,
  output logic                            q_push,
  output sslex_pkg::item_t                q_item
);
  import sslex_pkg::*;

  cls_t cls;

  always_comb begin
    cls.zero  = (ch == CH_NUL);
    cls.ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) ||
                (ch == CH_LF) || (ch == CH_FF) || (ch == CH_VT);
    cls.fbd   = (ch == CH_NUL) || (ch == CH_SPACE) || (ch == CH_TAB) ||
                (ch == CH_CR) || (ch == CH_LF);
    cls.quote = (ch == CH_QUOTE);
    cls.slash = (ch == CH_SLASH);
    cls.star  = (ch == CH_STAR);
    cls.is_n  = (ch == CH_UC_N) || (ch == CH_LC_N);
    cls.is_q  = (ch == CH_UC_Q) || (ch == CH_LC_Q);
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.ch      = ch;
    q_item.en      = {want_comment, want_qstring, want_string};
    q_item.cls     = cls;
    q_item.partner = partner_of(ch);
  end

endmodule

`default_nettype wire

>>> sv/sslex_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sslex_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sslex_pkg::item_t push_item,
  input  wire logic             pop,
  output sslex_pkg::item_t      pop_item,
  output logic                  full,
  output logic                  empty
);
  import sslex_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t            mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/sslex_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sslex_back #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sslex_pkg::item_t            q_item,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       verdict,
  output logic [sslex_pkg::OUT_W-1:0]      skipped,
  output logic [sslex_pkg::OUT_W-1:0]      token_length
);
  import sslex_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SKIP   = 4'd1;
  localparam logic [3:0] PH_SLASH  = 4'd2;
  localparam logic [3:0] PH_NPRE   = 4'd3;
  localparam logic [3:0] PH_QQUOTE = 4'd4;
  localparam logic [3:0] PH_QOPEN  = 4'd5;
  localparam logic [3:0] PH_QBODY  = 4'd6;
  localparam logic [3:0] PH_QCLOSE = 4'd7;
  localparam logic [3:0] PH_OBODY  = 4'd8;
  localparam logic [3:0] PH_OQUOTE = 4'd9;
  localparam logic [3:0] PH_CBODY  = 4'd10;
  localparam logic [3:0] PH_CSTAR  = 4'd11;

  typedef struct packed {
    logic       fin;
    logic       bump;
    logic [3:0] phase;
  } step_t;

  logic [3:0]            phase, phase_next;
  logic [CH_W-1:0]       close_char, close_char_next;
  logic [EN_W-1:0]       enables, enables_next;
  logic [COUNT_BITS-1:0] skip_count, skip_count_next;
  logic [COUNT_BITS-1:0] token_count, token_count_next;
  logic                  fin;
  logic [1:0]            fin_verdict;
  step_t                 st;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[OUT_W-1:0];
  endfunction

  function automatic step_t after_prefix(input cls_t c, input logic [EN_W-1:0] en);
    step_t s;
    s = '{fin: 1'b0, bump: 1'b1, phase: PH_IDLE};
    priority if (en[EN_Q] && c.is_q) begin
      s.phase = PH_QQUOTE;
    end else if (en[EN_STR] && c.quote) begin
      s.phase = PH_OBODY;
    end else begin
      s.fin  = 1'b1;
      s.bump = 1'b0;
    end
    return s;
  endfunction

  function automatic step_t first_char(input cls_t c, input logic [EN_W-1:0] en);
    step_t s;
    s = '{fin: 1'b0, bump: 1'b1, phase: PH_IDLE};
    priority if (c.zero) begin
      s.fin  = 1'b1;
      s.bump = 1'b0;
    end else if (en[EN_CMT] && c.slash) begin
      s.phase = PH_SLASH;
    end else if (!(en[EN_STR] || en[EN_Q])) begin
      s.fin  = 1'b1;
      s.bump = 1'b0;
    end else if (c.is_n) begin
      s.phase = PH_NPRE;
    end else begin
      s = after_prefix(c, en);
    end
    return s;
  endfunction

  // take the next item only when the result register is free or drains now
  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_comb begin
    phase_next       = phase;
    close_char_next  = close_char;
    enables_next     = enables;
    skip_count_next  = skip_count;
    token_count_next = token_count;
    fin              = 1'b0;
    fin_verdict      = V_NONE;
    st               = '0;
    unique case (phase)
      PH_SKIP: begin
        if (q_item.cls.ws) begin
          skip_count_next = bump(skip_count);
        end else begin
          st = first_char(q_item.cls, enables);
          fin = st.fin;
          phase_next = st.phase;
          if (st.bump) token_count_next = bump(token_count);
        end
      end
      PH_SLASH: begin
        if (q_item.cls.star) begin
          token_count_next = bump(token_count);
          phase_next = PH_CBODY;
        end else begin
          fin = 1'b1;
        end
      end
      PH_NPRE: begin
        if (q_item.cls.quote || q_item.cls.is_q) begin
          st = after_prefix(q_item.cls, enables);
          fin = st.fin;
          phase_next = st.phase;
          if (st.bump) token_count_next = bump(token_count);
        end else begin
          fin = 1'b1;
        end
      end
      PH_QQUOTE: begin
        if (q_item.cls.quote) begin
          token_count_next = bump(token_count);
          phase_next = PH_QOPEN;
        end else begin
          fin = 1'b1;
        end
      end
      PH_QOPEN: begin
        if (q_item.cls.fbd) begin
          fin = 1'b1;
        end else begin
          close_char_next  = q_item.partner;
          token_count_next = bump(token_count);
          phase_next = PH_QBODY;
        end
      end
      PH_QBODY, PH_QCLOSE: begin
        priority if (phase == PH_QCLOSE && q_item.cls.quote) begin
          token_count_next = bump(token_count);
          fin = 1'b1;
          fin_verdict = V_Q;
        end else if (q_item.cls.zero) begin
          fin = 1'b1;
        end else begin
          token_count_next = bump(token_count);
          phase_next = (q_item.ch == close_char) ? PH_QCLOSE : PH_QBODY;
        end
      end
      PH_OBODY: begin
        if (q_item.cls.zero) begin
          fin = 1'b1;
        end else begin
          token_count_next = bump(token_count);
          if (q_item.cls.quote) phase_next = PH_OQUOTE;
        end
      end
      PH_OQUOTE: begin
        if (q_item.cls.quote) begin
          token_count_next = bump(token_count);
          phase_next = PH_OBODY;
        end else begin
          fin = 1'b1;
          fin_verdict = V_STR;
        end
      end
      PH_CBODY, PH_CSTAR: begin
        priority if (phase == PH_CSTAR && q_item.cls.slash) begin
          token_count_next = bump(token_count);
          fin = 1'b1;
          fin_verdict = V_CMT;
        end else if (q_item.cls.zero) begin
          fin = 1'b1;
        end else begin
          token_count_next = bump(token_count);
          phase_next = q_item.cls.star ? PH_CSTAR : PH_CBODY;
        end
      end
      default: begin
        // idle and unused codes: start of a scan
        enables_next     = q_item.en;
        skip_count_next  = '0;
        token_count_next = '0;
        close_char_next  = '0;
        priority if (q_item.en == '0) begin
          fin = 1'b1;
        end else if (q_item.cls.ws) begin
          skip_count_next = COUNT_BITS'(1);
          phase_next = PH_SKIP;
        end else begin
          st = first_char(q_item.cls, q_item.en);
          fin = st.fin;
          phase_next = st.phase;
          if (st.bump) token_count_next = COUNT_BITS'(1);
        end
      end
    endcase
    if (fin) phase_next = PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      close_char  <= '0;
      enables     <= '0;
      skip_count  <= '0;
      token_count <= '0;
    end else if (q_pop) begin
      phase       <= phase_next;
      close_char  <= close_char_next;
      enables     <= enables_next;
      skip_count  <= skip_count_next;
      token_count <= token_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && fin) begin
      verdict      <= fin_verdict;
      skipped      <= sat_out(skip_count_next);
      token_length <= (fin_verdict == V_NONE) ? '0 : sat_out(token_count_next);
    end
  end

endmodule

`default_nettype wire

>>> sv/sql_string_comment_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------------
// in       in_valid / in_ready   ch, want_string, want_qstring, want_comment
// out      out_valid / out_ready verdict, skipped, token_length
//
// One item per clock sustained while out_ready holds high. Each item is
// classified combinationally and written into the queue; the lexer state
// machine steps it from the queue and registers a finishing item's result.
// While a result waits on out_ready the lexer holds; the two-entry queue
// takes items until both entries are held, then in_ready drops.
// rst is synchronous: clears the queue, lexer phase, counters, result valid.
// No clearing pass after reset; in_ready is high on the first cycle after.

module sql_string_comment_lexer #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [sslex_pkg::CH_W-1:0] ch,
  input  wire logic                       want_string,
  input  wire logic                       want_qstring,
  input  wire logic                       want_comment,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      verdict,
  output logic [sslex_pkg::OUT_W-1:0]     skipped,
  output logic [sslex_pkg::OUT_W-1:0]     token_length
);
  import sslex_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  // front: classify each character (whitespace, quote, prefix, delimiter
  // partner) so the back state machine sees only flags and compares
  sslex_front u_front (
    .ch           (ch),
    .want_string  (want_string),
    .want_qstring (want_qstring),
    .want_comment (want_comment),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // short queue decoupling intake from the lexer
  sslex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: lexer phase machine, saturating counters, result register
  sslex_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (pop_item),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .skipped      (skipped),
    .token_length (token_length)
  );

`ifndef SYNTHESIS
  // a rejection never carries a length
  a_reject_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == V_NONE) |-> (token_length == '0))
    else $error("rejection with nonzero token length");

  // shortest ordinary string is two quotes; q-string q'xx' is five
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (verdict == V_STR || verdict == V_Q || verdict == V_CMT)) |->
    ((verdict == V_STR && token_length >= 16'd2) ||
     (verdict == V_Q && token_length >= 16'd5) ||
     (verdict == V_CMT && token_length >= 16'd4)))
    else $error("accepted token shorter than its minimum form");

  // a held result stalls the lexer
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("lexer stepped while result was stalled");

  // nothing enters the lexer from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> tb/sql_string_comment_lexer_tb.sv
`timescale 1ns / 1ps

module sql_string_comment_lexer_tb;
  import sslex_pkg::*;

  // enable sets for the first item of a scan
  localparam logic [2:0] ALLOW_STR = 3'b001 << EN_STR;
  localparam logic [2:0] ALLOW_Q   = 3'b001 << EN_Q;
  localparam logic [2:0] ALLOW_CMT = 3'b001 << EN_CMT;
  localparam logic [2:0] ALLOW_ALL = 3'b111;

  localparam logic [CH_W-1:0] CH_MAX = 21'h10FFFF;  // highest code point
  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  // lexer phases of the scoreboard's own scan tracker
  typedef enum logic [3:0] {
    LX_IDLE, LX_SKIP, LX_SLASH, LX_NPRE, LX_QQUOTE, LX_QOPEN,
    LX_QBODY, LX_QCLOSE, LX_OBODY, LX_OQUOTE, LX_CBODY, LX_CSTAR
  } lex_phase_e;

  typedef struct {
    logic [1:0]       verdict;
    logic [OUT_W-1:0] skipped;
    logic [OUT_W-1:0] length;
  } token_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CH_W-1:0]  ch = '0;
  logic             want_string = 1'b0;
  logic             want_qstring = 1'b0;
  logic             want_comment = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  logic [1:0]       verdict;
  logic [OUT_W-1:0] skipped;
  logic [OUT_W-1:0] token_length;

  sql_string_comment_lexer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .want_string  (want_string),
    .want_qstring (want_qstring),
    .want_comment (want_comment),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .skipped      (skipped),
    .token_length (token_length)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // idling knobs, flipped by the tests
  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned stall_left = 0;

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned verdict_seen [4];

  token_result_t expected_tokens [$];

  // ---------------------------------------------------------------------
  // Scan tracker: follows the lexer one accepted item at a time and
  // queues the token result that each finished scan must produce.
  // ---------------------------------------------------------------------
  lex_phase_e       lx_phase = LX_IDLE;
  logic [CH_W-1:0]  lx_close = '0;
  logic [2:0]       lx_en = '0;
  logic [OUT_W-1:0] lx_skip = '0;
  logic [OUT_W-1:0] lx_tok = '0;

  function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] n);
    return (n == '1) ? n : n + 1'b1;
  endfunction

  function automatic bit is_space(input logic [CH_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_FF || c == CH_VT;
  endfunction

  function automatic logic [CH_W-1:0] closing_for(input logic [CH_W-1:0] c);
    if (c == CH_LBRACK) return CH_RBRACK;
    if (c == CH_LBRACE) return CH_RBRACE;
    if (c == CH_LPAREN) return CH_RPAREN;
    if (c == CH_LT) return CH_GT;
    return c;  // any other delimiter closes with itself
  endfunction

  function automatic void end_scan(input logic [1:0] v);
    token_result_t r;
    r.verdict = v;
    r.skipped = lx_skip;
    r.length  = (v == V_NONE) ? '0 : lx_tok;
    expected_tokens.push_back(r);
    lx_phase = LX_IDLE;
  endfunction

  // character right after an optional N prefix, or the first one
  function automatic void after_prefix(input logic [CH_W-1:0] c);
    if (lx_en[EN_Q] && (c == CH_UC_Q || c == CH_LC_Q)) begin
      lx_tok = sat_inc(lx_tok);
      lx_phase = LX_QQUOTE;
    end else if (lx_en[EN_STR] && c == CH_QUOTE) begin
      lx_tok = sat_inc(lx_tok);
      lx_phase = LX_OBODY;
    end else begin
      end_scan(V_NONE);
    end
  endfunction

  // first character after leading whitespace
  function automatic void token_start(input logic [CH_W-1:0] c);
    if (c == CH_NUL) begin
      end_scan(V_NONE);
    end else if (lx_en[EN_CMT] && c == CH_SLASH) begin
      lx_tok = sat_inc(lx_tok);
      lx_phase = LX_SLASH;
    end else if (!lx_en[EN_STR] && !lx_en[EN_Q]) begin
      end_scan(V_NONE);
    end else if (c == CH_UC_N || c == CH_LC_N) begin
      lx_tok = sat_inc(lx_tok);
      lx_phase = LX_NPRE;
    end else begin
      after_prefix(c);
    end
  endfunction

  function automatic void lex_step(input logic [CH_W-1:0] c, input logic [2:0] en);
    case (lx_phase)
      LX_SKIP: begin
        if (is_space(c)) lx_skip = sat_inc(lx_skip);
        else token_start(c);
      end
      LX_SLASH: begin
        if (c == CH_STAR) begin
          lx_tok = sat_inc(lx_tok);
          lx_phase = LX_CBODY;
        end else begin
          end_scan(V_NONE);  // lone slash; no string may follow it
        end
      end
      LX_NPRE: begin
        if (c == CH_QUOTE || c == CH_UC_Q || c == CH_LC_Q) after_prefix(c);
        else end_scan(V_NONE);
      end
      LX_QQUOTE: begin
        if (c == CH_QUOTE) begin
          lx_tok = sat_inc(lx_tok);
          lx_phase = LX_QOPEN;
        end else begin
          end_scan(V_NONE);
        end
      end
      LX_QOPEN: begin
        if (c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
          end_scan(V_NONE);
        end else begin
          lx_close = closing_for(c);
          lx_tok = sat_inc(lx_tok);
          lx_phase = LX_QBODY;
        end
      end
      LX_QBODY, LX_QCLOSE: begin
        if (lx_phase == LX_QCLOSE && c == CH_QUOTE) begin
          lx_tok = sat_inc(lx_tok);
          end_scan(V_Q);
        end else if (c == CH_NUL) begin
          end_scan(V_NONE);
        end else begin
          lx_tok = sat_inc(lx_tok);
          lx_phase = (c == lx_close) ? LX_QCLOSE : LX_QBODY;
        end
      end
      LX_OBODY: begin
        if (c == CH_NUL) begin
          end_scan(V_NONE);
        end else begin
          lx_tok = sat_inc(lx_tok);
          if (c == CH_QUOTE) lx_phase = LX_OQUOTE;
        end
      end
      LX_OQUOTE: begin
        // doubled quote continues the body; anything else (NUL too) closes it
        if (c == CH_QUOTE) begin
          lx_tok = sat_inc(lx_tok);
          lx_phase = LX_OBODY;
        end else begin
          end_scan(V_STR);
        end
      end
      LX_CBODY, LX_CSTAR: begin
        if (lx_phase == LX_CSTAR && c == CH_SLASH) begin
          lx_tok = sat_inc(lx_tok);
          end_scan(V_CMT);
        end else if (c == CH_NUL) begin
          end_scan(V_NONE);
        end else begin
          lx_tok = sat_inc(lx_tok);
          lx_phase = (c == CH_STAR) ? LX_CSTAR : LX_CBODY;
        end
      end
      default: begin
        // new scan: enables are taken from this item only
        lx_en = en;
        lx_skip = '0;
        lx_tok = '0;
        lx_close = '0;
        if (en == '0) begin
          end_scan(V_NONE);
        end else if (is_space(c)) begin
          lx_skip = sat_inc(lx_skip);
          lx_phase = LX_SKIP;
        end else begin
          token_start(c);
        end
      end
    endcase
  endfunction

  // input monitor: every accepted item steps the tracker
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      lex_step(ch, {want_comment, want_qstring, want_string});
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 20)
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // result checker: oldest expectation against each accepted result item
  always @(posedge clk) begin : check_tokens
    token_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("result with no scan pending", 32'(verdict), 32'(V_NONE));
      end else begin
        want = expected_tokens.pop_front();
        verdict_seen[want.verdict]++;
        if (verdict !== want.verdict)
          report_mismatch("verdict", 32'(verdict), 32'(want.verdict));
        if (skipped !== want.skipped)
          report_mismatch("skipped", 32'(skipped), 32'(want.skipped));
        if (token_length !== want.length)
          report_mismatch("token_length", 32'(token_length), 32'(want.length));
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst || !receiver_stalls) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: any cycle without a handshake on either side counts. A result
  // that never arrives also lands here, since the drain loop keeps waiting.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Driving. in_valid is only lowered for a gap or a drain, so a held
  // valid is never dropped and raised in the same step.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [CH_W-1:0] c, input logic [2:0] en);
    int unsigned gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    ch           <= c;
    want_string  <= en[EN_STR];
    want_qstring <= en[EN_Q];
    want_comment <= en[EN_CMT];
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic [2:0] en);
    for (int i = 0; i < s.len(); i++) send_item(CH_W'(s[i]), en);
  endtask

  // sender holds off until every pending result item is back; the first
  // edge lets the monitor log the item accepted at the previous one
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Character pickers for random scans
  // ---------------------------------------------------------------------
  function automatic logic [CH_W-1:0] rand_space();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_FF;
      default: return CH_VT;
    endcase
  endfunction

  // never NUL; spans ASCII, lexer specials and the full code point range
  function automatic logic [CH_W-1:0] rand_body();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CH_W'($urandom_range(CH_SPACE, 'h7E));
      4, 5: begin
        case ($urandom_range(0, 11))
          0: return CH_QUOTE;
          1: return CH_STAR;
          2: return CH_SLASH;
          3: return CH_LF;
          4: return CH_CR;
          5: return CH_TAB;
          6: return CH_LBRACK;
          7: return CH_RBRACE;
          8: return CH_RPAREN;
          9: return CH_GT;
          10: return CH_UC_N;
          default: return CH_LC_Q;
        endcase
      end
      6: return CH_W'($urandom_range(1, 'h7FF));
      7: return CH_W'($urandom_range('h800, 'hFFFF));
      default: return CH_W'($urandom_range('h10000, CH_MAX));
    endcase
  endfunction

  function automatic logic [CH_W-1:0] rand_any();
    if ($urandom_range(0, 9) == 0) return CH_NUL;
    if ($urandom_range(0, 4) == 0) return rand_space();
    return rand_body();
  endfunction

  function automatic logic [CH_W-1:0] rand_delim();
    logic [CH_W-1:0] c;
    case ($urandom_range(0, 7))
      0: return CH_LBRACK;
      1: return CH_LBRACE;
      2: return CH_LPAREN;
      3: return CH_LT;
      default: begin
        do c = rand_body();
        while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
        return c;
      end
    endcase
  endfunction

  function automatic int unsigned body_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // all enables clear: first item rejected at once, here the top code point
  task automatic test_enables_off();
    send_item(CH_MAX, 3'b000);
    wait_drained();
  endtask

  // N prefix, doubled quote, NUL right after the closing quote accepts;
  // then a string closed by an ordinary character
  task automatic test_plain_string();
    send_item(CH_VT, ALLOW_STR);
    send_text("N'a''b'", ALLOW_STR);
    send_item(CH_NUL, ALLOW_STR);
    send_text("'a'b", ALLOW_STR | ALLOW_Q);
    wait_drained();
  endtask

  // bracket pair, close char not followed by a quote stays content
  task automatic test_qstring();
    send_text("q'<a>b>'", ALLOW_Q);
    wait_drained();
  endtask

  // star runs and the top code point inside a comment
  task automatic test_block_comment();
    send_text("/*", ALLOW_CMT);
    send_item(CH_MAX, ALLOW_CMT);
    send_text("**/", ALLOW_CMT);
    wait_drained();
  endtask

  task automatic test_rejects();
    send_text("/x", ALLOW_ALL);         // slash without star
    send_text("/", ALLOW_STR);          // slash with comments off
    send_text("Nx", ALLOW_STR);         // N not followed by quote or Q
    send_text("Qx", ALLOW_Q);           // Q not followed by quote
    send_text("q'", ALLOW_Q);
    send_item(CH_TAB, ALLOW_Q);         // forbidden delimiter
    send_text("#", ALLOW_ALL);          // nothing can start here
    send_text("'a", ALLOW_STR);
    send_item(CH_NUL, ALLOW_STR);       // end of input inside a string
    send_item(CH_NUL, ALLOW_ALL);       // end of input before any token
    wait_drained();
  endtask

  // Mostly well-formed scans with random content, the rest noise or scans
  // cut short. Anything that may leave a scan open gets a trailing NUL, so
  // every well-formed scan starts from idle.
  task automatic test_random_scans();
    logic [CH_W-1:0] text [$];
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] close_ch;
    logic [2:0]      en;
    int unsigned     kind;
    int unsigned     n;
    int unsigned     sent;
    bit              tidy;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      text.delete();
      sender_gaps = ($urandom_range(0, 4) != 0);
      receiver_stalls = ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 9);
      en = 3'($urandom_range(0, 7));
      tidy = 1'b1;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      repeat (n) text.push_back(rand_space());
      if (kind <= 2) begin
        en[EN_STR] = 1'b1;
        if ($urandom_range(0, 3) == 0) text.push_back($urandom_range(0, 1) ? CH_UC_N : CH_LC_N);
        text.push_back(CH_QUOTE);
        n = body_len();
        repeat (n) begin
          c = rand_body();
          text.push_back(c);
          if (c == CH_QUOTE) text.push_back(CH_QUOTE);  // escaped quote
        end
        text.push_back(CH_QUOTE);
        // the string only closes on the item after its quote
        if ($urandom_range(0, 2) == 0) begin
          text.push_back(CH_NUL);
        end else begin
          do c = rand_body();
          while (c == CH_QUOTE);
          text.push_back(c);
        end
      end else if (kind <= 4) begin
        en[EN_Q] = 1'b1;
        if ($urandom_range(0, 3) == 0) text.push_back($urandom_range(0, 1) ? CH_UC_N : CH_LC_N);
        text.push_back($urandom_range(0, 1) ? CH_UC_Q : CH_LC_Q);
        text.push_back(CH_QUOTE);
        c = rand_delim();
        text.push_back(c);
        close_ch = closing_for(c);
        n = body_len();
        repeat (n) begin
          do c = rand_body();
          while (c == close_ch);
          text.push_back(c);
          if ($urandom_range(0, 5) == 0) begin
            // close char without a quote after it
            text.push_back(close_ch);
            do c = rand_body();
            while (c == CH_QUOTE || c == close_ch);
            text.push_back(c);
          end
        end
        text.push_back(close_ch);
        text.push_back(CH_QUOTE);
      end else if (kind <= 6) begin
        en[EN_CMT] = 1'b1;
        text.push_back(CH_SLASH);
        text.push_back(CH_STAR);
        n = body_len();
        repeat (n) begin
          c = rand_body();
          if (c == CH_SLASH && text[$] == CH_STAR) c = CH_STAR;
          text.push_back(c);
        end
        text.push_back(CH_STAR);
        text.push_back(CH_SLASH);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) text.push_back(rand_any());
        tidy = 1'b0;
      end
      if (kind <= 6 && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, text.size() - 1);
        while (text.size() > n) void'(text.pop_back());
        text.push_back(rand_any());
        tidy = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        en = 3'($urandom_range(0, 7));
        tidy = 1'b0;
      end
      if (!tidy) text.push_back(CH_NUL);  // NUL closes whatever is open
      foreach (text[i]) send_item(text[i], (i == 0) ? en : 3'($urandom_range(0, 7)));
      sent += text.size();
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_enables_off();
    test_plain_string();
    test_qstring();
    test_block_comment();
    test_rejects();
    test_random_scans();
    $display("covered %0d items over directed and random scans; results: %0d strings,",
             items_sent, verdict_seen[V_STR]);
    $display("  %0d q-strings, %0d comments, %0d rejections, %0d mismatches",
             verdict_seen[V_Q], verdict_seen[V_CMT], verdict_seen[V_NONE], mismatches);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
